>>> sv/cau_pkg.sv
package cau_pkg;

  // Fraction bits of the fixed-point format.
  localparam int FRAC_BITS = 16;

  // Quotient bits kept by the divider: 32 bits plus one to see overflow.
  localparam int QBITS = 33;
  localparam int NSTEP = QBITS;

  // Width of the operands and of the remainder inside the divider.
  localparam int DW = 32;
  localparam int RW = 64;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_CMP = 3'd4;

  // One divider lane in flight.
  typedef struct packed {
    logic [RW-1:0]    rem;
    logic [QBITS-1:0] nlow;
    logic [QBITS-1:0] quo;
    logic             neg;
    logic             ovf;
  } lane_t;

  // Everything else that rides along with a word through the divider.
  typedef struct packed {
    logic          is_div;
    logic [DW-1:0] re;
    logic [DW-1:0] im;
    logic          eq;
    logic          dz;
    logic          sat;
    logic [RW-1:0] den;
  } side_t;

endpackage

>>> sv/cau_div_step.sv
module cau_div_step (
  input  cau_pkg::lane_t              lane_i,
  input  logic [cau_pkg::RW-1:0]      den,
  output cau_pkg::lane_t              lane_o
);

  logic [cau_pkg::RW:0] trial;
  logic [cau_pkg::RW:0] diff;
  logic                 ge;

  // One restoring step: bring down the next dividend bit and try the subtract.
  assign trial = {lane_i.rem, lane_i.nlow[cau_pkg::QBITS-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};

  always_comb begin
    lane_o      = lane_i;
    lane_o.rem  = ge ? diff[cau_pkg::RW-1:0] : trial[cau_pkg::RW-1:0];
    lane_o.nlow = {lane_i.nlow[cau_pkg::QBITS-2:0], 1'b0};
    lane_o.quo  = {lane_i.quo[cau_pkg::QBITS-2:0], ge};
  end

endmodule

>>> sv/complex_arithmetic_unit.sv
// Complex add, subtract, multiply, divide and compare on signed Q16.16 operands.
// The unit is fully pipelined: it takes one word every cycle while in_stall is
// low. Most of the pipeline is the divider, a restoring divider unrolled into
// 33 register stages (one quotient bit per stage, both parts in parallel),
// behind three stages of multiply, sum and sign handling and one stage of
// dividend setup. Every kind of word takes the same path, so results leave in
// order. Empty stages close up while the output is stalled, so input is still
// taken until the pipeline is full.
module complex_arithmetic_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_a_real,
  input  logic signed [31:0] in_a_imag,
  input  logic signed [31:0] in_b_real,
  input  logic signed [31:0] in_b_imag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_res_real,
  output logic signed [31:0] out_res_imag,
  output logic               out_is_equal,
  output logic               out_div_zero,
  output logic               out_saturated
);

  localparam int F     = cau_pkg::FRAC_BITS;
  localparam int NSTEP = cau_pkg::NSTEP;
  localparam int QBITS = cau_pkg::QBITS;
  localparam int RW    = cau_pkg::RW;
  localparam int CW    = RW + QBITS;

  localparam logic signed [64:0] MAX65 = 65'sd2147483647;
  localparam logic signed [64:0] MIN65 = -65'sd2147483648;
  localparam logic signed [32:0] MAX33 = 33'sd2147483647;
  localparam logic signed [32:0] MIN33 = -33'sd2147483648;
  localparam logic signed [64:0] BIAS  = 65'sd1 <<< F;

  // Saturate a 33-bit sum; bit 32 of the result is the clamp flag.
  function automatic logic [32:0] sat33(input logic signed [32:0] v);
    logic [32:0] r;
    if (v > MAX33) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < MIN33) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // Clamp a divider quotient with its sign; bit 32 of the result is the clamp flag.
  function automatic logic [32:0] clamp_q(input cau_pkg::lane_t ln);
    logic [32:0] r;
    logic [31:0] q;
    q = ln.quo[31:0];
    if (!ln.neg) begin
      if (ln.ovf || ln.quo > 33'h0_7FFF_FFFF) begin
        r = {1'b1, 32'h7FFF_FFFF};
      end else begin
        r = {1'b0, q};
      end
    end else begin
      if (ln.ovf || ln.quo > 33'h0_8000_0000) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, 32'd0 - q};
      end
    end
    return r;
  endfunction

  // Ready chain: a stage loads when it is empty or the stage after it loads.
  logic             rdy1, rdy2, rdy3, rdy_pre, rdy_out;
  logic [NSTEP-1:0] rdy_st;

  // ---------------- Stage 1: products, add/sub/compare ----------------
  logic               s1_v_r;
  logic [2:0]         s1_kind_r;
  logic signed [63:0] s1_prr_r, s1_pii_r, s1_pri_r, s1_pir_r, s1_sqr_r, s1_sqi_r;
  logic [31:0]        s1_re_r, s1_im_r;
  logic               s1_eq_r, s1_dz_r, s1_sat_r;

  logic [32:0]        sum_re_nxt, sum_im_nxt;
  logic [31:0]        s1_re_nxt, s1_im_nxt;
  logic               s1_eq_nxt, s1_sat_nxt;

  always_comb begin
    sum_re_nxt = 33'd0;
    sum_im_nxt = 33'd0;
    s1_re_nxt  = 32'd0;
    s1_im_nxt  = 32'd0;
    s1_eq_nxt  = 1'b0;
    s1_sat_nxt = 1'b0;
    case (in_kind)
      cau_pkg::KIND_ADD: begin
        sum_re_nxt = sat33(33'(in_a_real) + 33'(in_b_real));
        sum_im_nxt = sat33(33'(in_a_imag) + 33'(in_b_imag));
        s1_re_nxt  = sum_re_nxt[31:0];
        s1_im_nxt  = sum_im_nxt[31:0];
        s1_sat_nxt = sum_re_nxt[32] | sum_im_nxt[32];
      end
      cau_pkg::KIND_SUB: begin
        sum_re_nxt = sat33(33'(in_a_real) - 33'(in_b_real));
        sum_im_nxt = sat33(33'(in_a_imag) - 33'(in_b_imag));
        s1_re_nxt  = sum_re_nxt[31:0];
        s1_im_nxt  = sum_im_nxt[31:0];
        s1_sat_nxt = sum_re_nxt[32] | sum_im_nxt[32];
      end
      cau_pkg::KIND_CMP: begin
        s1_eq_nxt = (in_a_real == in_b_real) && (in_a_imag == in_b_imag);
      end
      default: begin
        s1_re_nxt = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_kind_r <= in_kind;
      s1_prr_r  <= 64'(in_a_real) * 64'(in_b_real);
      s1_pii_r  <= 64'(in_a_imag) * 64'(in_b_imag);
      s1_pri_r  <= 64'(in_a_real) * 64'(in_b_imag);
      s1_pir_r  <= 64'(in_a_imag) * 64'(in_b_real);
      s1_sqr_r  <= 64'(in_b_real) * 64'(in_b_real);
      s1_sqi_r  <= 64'(in_b_imag) * 64'(in_b_imag);
      s1_re_r   <= s1_re_nxt;
      s1_im_r   <= s1_im_nxt;
      s1_eq_r   <= s1_eq_nxt;
      s1_sat_r  <= s1_sat_nxt;
      s1_dz_r   <= (in_kind == cau_pkg::KIND_DIV) && (in_b_real == 32'sd0) &&
                   (in_b_imag == 32'sd0);
    end
  end

  // ---------------- Stage 2: product sums ----------------
  logic               s2_v_r;
  logic [2:0]         s2_kind_r;
  logic signed [64:0] s2_mre_r, s2_mim_r, s2_dre_r, s2_dim_r;
  logic [RW-1:0]      s2_den_r;
  logic [31:0]        s2_re_r, s2_im_r;
  logic               s2_eq_r, s2_dz_r, s2_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_kind_r <= s1_kind_r;
      s2_mre_r  <= 65'(s1_prr_r) - 65'(s1_pii_r);
      s2_mim_r  <= 65'(s1_pri_r) + 65'(s1_pir_r);
      s2_dre_r  <= 65'(s1_prr_r) + 65'(s1_pii_r);
      s2_dim_r  <= 65'(s1_pir_r) - 65'(s1_pri_r);
      s2_den_r  <= $unsigned(s1_sqr_r) + $unsigned(s1_sqi_r);
      s2_re_r   <= s1_re_r;
      s2_im_r   <= s1_im_r;
      s2_eq_r   <= s1_eq_r;
      s2_dz_r   <= s1_dz_r;
      s2_sat_r  <= s1_sat_r;
    end
  end

  // ---------------- Stage 3: multiply result, dividend signs ----------------
  logic               s3_v_r;
  cau_pkg::side_t     s3_side_r;
  logic [RW-1:0]      s3_mag_re_r, s3_mag_im_r;
  logic               s3_neg_re_r, s3_neg_im_r;

  logic signed [64:0] mre_sh, mim_sh;
  logic signed [64:0] dre_abs, dim_abs;
  logic               mre_sat, mim_sat;
  logic [31:0]        mre_val, mim_val;
  cau_pkg::side_t     s3_side_nxt;

  // Adding 2^F - 1 to a negative sum before the arithmetic shift rounds toward zero.
  assign mre_sh  = (s2_mre_r + (s2_mre_r[64] ? BIAS - 65'sd1 : 65'sd0)) >>> F;
  assign mim_sh  = (s2_mim_r + (s2_mim_r[64] ? BIAS - 65'sd1 : 65'sd0)) >>> F;
  assign mre_sat = (mre_sh > MAX65) || (mre_sh < MIN65);
  assign mim_sat = (mim_sh > MAX65) || (mim_sh < MIN65);
  assign mre_val = (mre_sh > MAX65) ? 32'h7FFF_FFFF :
                   (mre_sh < MIN65) ? 32'h8000_0000 : mre_sh[31:0];
  assign mim_val = (mim_sh > MAX65) ? 32'h7FFF_FFFF :
                   (mim_sh < MIN65) ? 32'h8000_0000 : mim_sh[31:0];
  assign dre_abs = s2_dre_r[64] ? -s2_dre_r : s2_dre_r;
  assign dim_abs = s2_dim_r[64] ? -s2_dim_r : s2_dim_r;

  always_comb begin
    s3_side_nxt        = '0;
    s3_side_nxt.den    = s2_den_r;
    s3_side_nxt.eq     = s2_eq_r;
    s3_side_nxt.dz     = s2_dz_r;
    s3_side_nxt.is_div = (s2_kind_r == cau_pkg::KIND_DIV) && !s2_dz_r;
    case (s2_kind_r)
      cau_pkg::KIND_MUL: begin
        s3_side_nxt.re  = mre_val;
        s3_side_nxt.im  = mim_val;
        s3_side_nxt.sat = mre_sat | mim_sat;
      end
      cau_pkg::KIND_DIV: begin
        s3_side_nxt.re = 32'd0;
      end
      default: begin
        s3_side_nxt.re  = s2_re_r;
        s3_side_nxt.im  = s2_im_r;
        s3_side_nxt.sat = s2_sat_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (rdy3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_side_r   <= s3_side_nxt;
      s3_mag_re_r <= dre_abs[RW-1:0];
      s3_mag_im_r <= dim_abs[RW-1:0];
      s3_neg_re_r <= s2_dre_r[64];
      s3_neg_im_r <= s2_dim_r[64];
    end
  end

  // ---------------- Divider setup ----------------
  logic             pre_v_r;
  cau_pkg::side_t   pre_side_r;
  cau_pkg::lane_t   pre_re_r, pre_im_r;

  logic [CW-1:0]    n_re, n_im, den_ext;
  cau_pkg::lane_t   pre_re_nxt, pre_im_nxt;

  // The quotient fits in QBITS bits exactly when the scaled dividend is below
  // the divisor shifted up by QBITS; otherwise the part saturates.
  assign n_re    = CW'(s3_mag_re_r) << F;
  assign n_im    = CW'(s3_mag_im_r) << F;
  assign den_ext = CW'(s3_side_r.den) << QBITS;

  always_comb begin
    pre_re_nxt.rem  = n_re[QBITS +: RW];
    pre_re_nxt.nlow = n_re[QBITS-1:0];
    pre_re_nxt.quo  = '0;
    pre_re_nxt.neg  = s3_neg_re_r;
    pre_re_nxt.ovf  = n_re >= den_ext;
    pre_im_nxt.rem  = n_im[QBITS +: RW];
    pre_im_nxt.nlow = n_im[QBITS-1:0];
    pre_im_nxt.quo  = '0;
    pre_im_nxt.neg  = s3_neg_im_r;
    pre_im_nxt.ovf  = n_im >= den_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= 1'b0;
    end else if (rdy_pre) begin
      pre_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_pre) begin
      pre_side_r <= s3_side_r;
      pre_re_r   <= pre_re_nxt;
      pre_im_r   <= pre_im_nxt;
    end
  end

  // ---------------- Divider steps ----------------
  logic [NSTEP-1:0] dv_r;
  cau_pkg::side_t   sd_r  [NSTEP];
  cau_pkg::lane_t   lre_r [NSTEP];
  cau_pkg::lane_t   lim_r [NSTEP];

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic           v_in;
    cau_pkg::side_t sd_in;
    cau_pkg::lane_t re_in, im_in, re_nxt, im_nxt;

    if (k == 0) begin : g_first
      assign v_in  = pre_v_r;
      assign sd_in = pre_side_r;
      assign re_in = pre_re_r;
      assign im_in = pre_im_r;
    end else begin : g_rest
      assign v_in  = dv_r[k-1];
      assign sd_in = sd_r[k-1];
      assign re_in = lre_r[k-1];
      assign im_in = lim_r[k-1];
    end

    cau_div_step u_re (.lane_i(re_in), .den(sd_in.den), .lane_o(re_nxt));
    cau_div_step u_im (.lane_i(im_in), .den(sd_in.den), .lane_o(im_nxt));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (rdy_st[k]) begin
        dv_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy_st[k]) begin
        sd_r[k]  <= sd_in;
        lre_r[k] <= re_nxt;
        lim_r[k] <= im_nxt;
      end
    end

    if (k == NSTEP - 1) begin : g_last
      assign rdy_st[k] = !dv_r[k] || rdy_out;
    end else begin : g_mid
      assign rdy_st[k] = !dv_r[k] || rdy_st[k+1];
    end
  end

  // ---------------- Output register ----------------
  logic           out_v_r;
  logic [31:0]    out_re_r, out_im_r;
  logic           out_eq_r, out_dz_r, out_sat_r;

  cau_pkg::side_t last_side;
  logic [32:0]    q_re, q_im;

  assign last_side = sd_r[NSTEP-1];
  assign q_re      = clamp_q(lre_r[NSTEP-1]);
  assign q_im      = clamp_q(lim_r[NSTEP-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy_out) begin
      out_v_r <= dv_r[NSTEP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_eq_r <= last_side.eq;
      out_dz_r <= last_side.dz;
      if (last_side.is_div) begin
        out_re_r  <= q_re[31:0];
        out_im_r  <= q_im[31:0];
        out_sat_r <= q_re[32] | q_im[32];
      end else begin
        out_re_r  <= last_side.re;
        out_im_r  <= last_side.im;
        out_sat_r <= last_side.sat;
      end
    end
  end

  assign rdy_out = !out_v_r || !out_stall;
  assign rdy_pre = !pre_v_r || rdy_st[0];
  assign rdy3    = !s3_v_r || rdy_pre;
  assign rdy2    = !s2_v_r || rdy3;
  assign rdy1    = !s1_v_r || rdy2;

  assign in_stall      = !rdy1;
  assign out_valid     = out_v_r;
  assign out_res_real  = out_re_r;
  assign out_res_imag  = out_im_r;
  assign out_is_equal  = out_eq_r;
  assign out_div_zero  = out_dz_r;
  assign out_saturated = out_sat_r;

endmodule

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] ar, ai, br, bi;
  } operands_t;

  typedef struct {
    logic signed [31:0] re, im;
    logic               eq, dz, sat;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_kind = '0;
  logic signed [31:0] in_a_real = '0, in_a_imag = '0, in_b_real = '0, in_b_imag = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_res_real, out_res_imag;
  logic               out_is_equal, out_div_zero, out_saturated;

  operands_t pending_words[$];
  outcome_t  expected_results[$];
  int        error_count = 0;
  int        idle_cycles = 0;
  bit        stimulus_done = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_phase = 0;

  complex_arithmetic_unit DUT (.*);

  always #5 clk = ~clk;

  // Clamp an exact value to the signed 32-bit range.
  function automatic logic signed [31:0] clamp_q(input logic signed [127:0] v,
                                                 inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Signed division truncated toward zero, done on magnitudes.
  function automatic logic signed [127:0] quot_trunc(input logic signed [127:0] n,
                                                     input logic signed [127:0] d);
    logic [127:0] mag;
    logic [127:0] q;
    mag = n < 0 ? -n : n;
    q = mag / d;
    return n < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic outcome_t compute_complex(input operands_t w);
    outcome_t r;
    logic signed [127:0] ar, ai, br, bi, den, pr, pi;
    logic sat;
    ar = w.ar; ai = w.ai; br = w.br; bi = w.bi;
    r = '{default: '0};
    sat = 1'b0;
    case (w.kind)
      cau_pkg::KIND_ADD: begin
        r.re = clamp_q(ar + br, sat);
        r.im = clamp_q(ai + bi, sat);
      end
      cau_pkg::KIND_SUB: begin
        r.re = clamp_q(ar - br, sat);
        r.im = clamp_q(ai - bi, sat);
      end
      cau_pkg::KIND_MUL: begin
        pr = quot_trunc(ar * br - ai * bi, 128'sd1 <<< cau_pkg::FRAC_BITS);
        pi = quot_trunc(ar * bi + ai * br, 128'sd1 <<< cau_pkg::FRAC_BITS);
        r.re = clamp_q(pr, sat);
        r.im = clamp_q(pi, sat);
      end
      cau_pkg::KIND_DIV: begin
        if (br == 0 && bi == 0) begin
          r.dz = 1'b1;
        end else begin
          den = br * br + bi * bi;
          pr = quot_trunc((ar * br + ai * bi) <<< cau_pkg::FRAC_BITS, den);
          pi = quot_trunc((ai * br - ar * bi) <<< cau_pkg::FRAC_BITS, den);
          r.re = clamp_q(pr, sat);
          r.im = clamp_q(pi, sat);
        end
      end
      cau_pkg::KIND_CMP: r.eq = (w.ar == w.br && w.ai == w.bi);
      default: ;
    endcase
    r.sat = sat;
    return r;
  endfunction

  function automatic logic signed [31:0] random_operand();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff - $urandom_range(0, 3);
      1: return 32'sh80000000 + $urandom_range(0, 3);
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      4: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_word(input logic [2:0] k, input logic signed [31:0] ar, ai, br, bi);
    operands_t w;
    w.kind = k; w.ar = ar; w.ai = ai; w.br = br; w.bi = bi;
    pending_words.push_back(w);
  endtask

  initial begin
    operands_t w;
    logic [2:0] k;
    for (int i = 0; i < 8; i++) begin
      k = 3'(i);
      queue_word(k, 32'sh00018000, -32'sh00008000, 32'sh00020000, 32'sh00010000);
    end
    queue_word(cau_pkg::KIND_ADD, 32'sh7fffffff, 32'sh80000000, 32'sd1, -32'sd1);
    queue_word(cau_pkg::KIND_SUB, 32'sh80000000, 32'sh7fffffff, 32'sd1, -32'sd1);
    queue_word(cau_pkg::KIND_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000,
               32'sh80000000);
    queue_word(cau_pkg::KIND_MUL, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
               32'sh7fffffff);
    queue_word(cau_pkg::KIND_MUL, -32'sd1, 32'sd1, 32'sd1, 32'sd1);
    queue_word(cau_pkg::KIND_DIV, 32'sh7fffffff, 32'sh80000000, 32'sd0, 32'sd0);
    queue_word(cau_pkg::KIND_DIV, 32'sh7fffffff, 32'sh80000000, 32'sd1, 32'sd0);
    queue_word(cau_pkg::KIND_DIV, 32'sh80000000, 32'sh80000000, 32'sh80000000,
               32'sh80000000);
    queue_word(cau_pkg::KIND_DIV, -32'sd5, 32'sd3, 32'sh7fffffff, 32'sh80000000);
    queue_word(cau_pkg::KIND_DIV, 32'sd1, 32'sd0, 32'sd0, -32'sd1);
    queue_word(cau_pkg::KIND_CMP, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
               32'sh7fffffff);
    queue_word(cau_pkg::KIND_CMP, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
               32'sh7ffffffe);
    queue_word(cau_pkg::KIND_CMP, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    for (int i = 0; i < 2000; i++) begin
      w.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
      w.ar = random_operand(); w.ai = random_operand();
      w.br = random_operand(); w.bi = random_operand();
      if (w.kind == cau_pkg::KIND_CMP && $urandom_range(0, 1)) begin
        w.br = w.ar;
        w.bi = $urandom_range(0, 1) ? w.ai : w.ai ^ (32'sd1 <<< $urandom_range(0, 31));
      end
      if (w.kind == cau_pkg::KIND_DIV && $urandom_range(0, 15) == 0) begin
        w.br = 32'sd0;
        w.bi = 32'sd0;
      end
      pending_words.push_back(w);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    stimulus_done = 1'b1;
  end

  // Sender: bursts of random length separated by random gaps. The word on
  // offer is always the head of the queue until it is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(compute_complex(pending_words.pop_front()));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid  <= 1'b1;
          in_kind   <= pending_words[0].kind;
          in_a_real <= pending_words[0].ar;
          in_a_imag <= pending_words[0].ai;
          in_b_real <= pending_words[0].br;
          in_b_imag <= pending_words[0].bi;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 60);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: quiet stretches, stretches of sparse stalls and stretches of dense stalls.
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 400;
    if (stall_phase < 120) out_stall <= 1'b0;
    else if (stall_phase < 250) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result word with no expectation waiting");
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_res_real !== e.re) begin
          $error("res_real expected %0d actual %0d", e.re, out_res_real);
          error_count++;
        end
        if (out_res_imag !== e.im) begin
          $error("res_imag expected %0d actual %0d", e.im, out_res_imag);
          error_count++;
        end
        if (out_is_equal !== e.eq) begin
          $error("is_equal expected %0d actual %0d", e.eq, out_is_equal);
          error_count++;
        end
        if (out_div_zero !== e.dz) begin
          $error("div_zero expected %0d actual %0d", e.dz, out_div_zero);
          error_count++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated expected %0d actual %0d", e.sat, out_saturated);
          error_count++;
        end
      end
    end
  end

  // Watchdog and end of run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done);
    wait (pending_words.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
